// ----- rtl/tcc_pkg.sv -----
// Shared types and constants for the text command to control byte converter.
package tcc_pkg;

    localparam int CHAR_W = 8;
    localparam int BYTE_W = 8;

    localparam logic [CHAR_W-1:0] CH_T     = 8'h74;
    localparam logic [CHAR_W-1:0] CH_R     = 8'h72;
    localparam logic [CHAR_W-1:0] CH_V     = 8'h76;
    localparam logic [CHAR_W-1:0] CH_S_LO  = 8'h73;
    localparam logic [CHAR_W-1:0] CH_W     = 8'h77;
    localparam logic [CHAR_W-1:0] CH_Q     = 8'h71;
    localparam logic [CHAR_W-1:0] CH_S_UP  = 8'h53;
    localparam logic [CHAR_W-1:0] CH_C_UP  = 8'h43;
    localparam logic [CHAR_W-1:0] CH_C_LO  = 8'h63;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    localparam logic [BYTE_W-1:0] RV_STOP_BYTE    = 8'h00;
    localparam logic [BYTE_W-1:0] RV_REVERSE_BYTE = 8'd15;
    localparam logic [BYTE_W-1:0] RV_RESUME_BYTE  = 8'd14;
    localparam logic [BYTE_W-1:0] SW_SOLENOID_OFF = 8'd32;

    localparam logic CFG_STRAIGHT_CODE = 1'b0;
    localparam logic CFG_CURVED_CODE   = 1'b1;

    localparam logic KIND_CONTROL = 1'b0;
    localparam logic KIND_QUIT    = 1'b1;

    typedef enum logic [2:0] {
        CMD_NONE = 3'd0,
        CMD_TR   = 3'd1,
        CMD_RV   = 3'd2,
        CMD_SW   = 3'd3,
        CMD_QUIT = 3'd4
    } cmd_kind_t;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_DONE   = 2'd2
    } field_phase_t;

    // num_a: first number; num_b: speed for tr, direction code for sw
    typedef struct packed {
        cmd_kind_t         kind;
        logic [BYTE_W-1:0] num_a;
        logic [BYTE_W-1:0] num_b;
    } cmd_rec_t;

    localparam int REC_W = $bits(cmd_rec_t);

endpackage

// ----- rtl/tcc_front.sv -----
// Line parser: accepts characters and queues one command record per completed line that holds a command.
module tcc_front import tcc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              char_valid,
    output logic              char_ready,
    input  logic [CHAR_W-1:0] char_in,
    input  logic [BYTE_W-1:0] straight_code,
    input  logic [BYTE_W-1:0] curved_code,
    input  logic              q_full,
    output logic              q_push,
    output cmd_rec_t          q_rec
);

    logic [1:0]        line_pos_reg, line_pos_next;
    logic [CHAR_W-1:0] first_char_reg, first_char_next;
    logic [CHAR_W-1:0] second_char_reg, second_char_next;
    cmd_kind_t         kind_reg, kind_next;
    field_phase_t      phase_reg, phase_next;
    logic [BYTE_W-1:0] num_one_reg, num_one_next;
    logic [BYTE_W-1:0] num_two_reg, num_two_next;
    logic [CHAR_W-1:0] dir_char_reg, dir_char_next;

    logic              accept;
    logic              is_eol;
    logic              is_digit;
    logic [BYTE_W-1:0] add_one;
    logic [BYTE_W-1:0] add_two;
    logic [BYTE_W-1:0] dir_code;

    assign char_ready = !q_full;
    assign accept     = char_valid && char_ready;
    assign is_eol     = (char_in == CH_CR) || (char_in == CH_LF);
    assign is_digit   = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
    assign add_one    = (num_one_reg << 3) + (num_one_reg << 1) + {4'd0, char_in[3:0]};
    assign add_two    = (num_two_reg << 3) + (num_two_reg << 1) + {4'd0, char_in[3:0]};

    always_comb begin
        dir_code = '0;
        if ((dir_char_reg == CH_S_UP) || (dir_char_reg == CH_S_LO)) begin
            dir_code = straight_code;
        end
        if ((dir_char_reg == CH_C_UP) || (dir_char_reg == CH_C_LO)) begin
            dir_code = curved_code;
        end
    end

    assign q_push      = accept && is_eol && (kind_reg != CMD_NONE);
    assign q_rec.kind  = kind_reg;
    assign q_rec.num_a = num_one_reg;
    assign q_rec.num_b = (kind_reg == CMD_SW) ? dir_code : num_two_reg;

    always_comb begin
        line_pos_next    = line_pos_reg;
        first_char_next  = first_char_reg;
        second_char_next = second_char_reg;
        kind_next        = kind_reg;
        phase_next       = phase_reg;
        num_one_next     = num_one_reg;
        num_two_next     = num_two_reg;
        dir_char_next    = dir_char_reg;
        if (accept && (char_in != CH_NUL)) begin
            if (is_eol) begin
                line_pos_next    = '0;
                first_char_next  = '0;
                second_char_next = '0;
                kind_next        = CMD_NONE;
                phase_next       = PH_FIRST;
                num_one_next     = '0;
                num_two_next     = '0;
                dir_char_next    = '0;
            end else begin
                case (line_pos_reg)
                    2'd0: begin
                        first_char_next = char_in;
                        if (char_in == CH_Q) begin
                            kind_next = CMD_QUIT;
                        end
                        line_pos_next = 2'd1;
                    end
                    2'd1: begin
                        second_char_next = char_in;
                        line_pos_next    = 2'd2;
                    end
                    2'd2: begin
                        if (char_in == CH_SPACE) begin
                            if (first_char_reg == CH_T && second_char_reg == CH_R) begin
                                kind_next = CMD_TR;
                            end else if (first_char_reg == CH_R && second_char_reg == CH_V) begin
                                kind_next = CMD_RV;
                            end else if (first_char_reg == CH_S_LO
                                         && second_char_reg == CH_W) begin
                                kind_next = CMD_SW;
                            end
                        end
                        line_pos_next = 2'd3;
                    end
                    default: begin
                        case (kind_reg)
                            CMD_TR: begin
                                if (phase_reg == PH_FIRST) begin
                                    if (is_digit) num_one_next = add_one;
                                    else phase_next = PH_SECOND;
                                end else if (phase_reg == PH_SECOND) begin
                                    if (is_digit) num_two_next = add_two;
                                    else phase_next = PH_DONE;
                                end
                            end
                            CMD_RV: begin
                                if (phase_reg == PH_FIRST) begin
                                    if (is_digit) num_one_next = add_one;
                                    else phase_next = PH_DONE;
                                end
                            end
                            CMD_SW: begin
                                if (phase_reg == PH_FIRST) begin
                                    if (is_digit) num_one_next = add_one;
                                    else phase_next = PH_SECOND;
                                end else if (phase_reg == PH_SECOND) begin
                                    dir_char_next = char_in;
                                    phase_next    = PH_DONE;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_pos_reg    <= '0;
            first_char_reg  <= '0;
            second_char_reg <= '0;
            kind_reg        <= CMD_NONE;
            phase_reg       <= PH_FIRST;
            num_one_reg     <= '0;
            num_two_reg     <= '0;
            dir_char_reg    <= '0;
        end else begin
            line_pos_reg    <= line_pos_next;
            first_char_reg  <= first_char_next;
            second_char_reg <= second_char_next;
            kind_reg        <= kind_next;
            phase_reg       <= phase_next;
            num_one_reg     <= num_one_next;
            num_two_reg     <= num_two_next;
            dir_char_reg    <= dir_char_next;
        end
    end

    a_phase_after_header: assert property (@(posedge aclk) disable iff (!aresetn)
        (line_pos_reg != 2'd3) |-> (phase_reg == PH_FIRST))
        else $error("field phase advanced before command header");

    a_kind_from_header: assert property (@(posedge aclk) disable iff (!aresetn)
        ((kind_reg == CMD_TR) || (kind_reg == CMD_RV) || (kind_reg == CMD_SW))
        |-> (line_pos_reg == 2'd3))
        else $error("command recognized before third character");

endmodule

// ----- rtl/tcc_cmd_fifo.sv -----
// Short command record queue between the parser and the byte sequencer.
module tcc_cmd_fifo import tcc_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  cmd_rec_t push_rec,
    output logic     full,
    input  logic     pop,
    output logic     not_empty,
    output cmd_rec_t head_rec
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cmd_rec_t          mem_reg [DEPTH];
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head_rec  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("record pushed into full queue");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("queue count out of range");

endmodule

// ----- rtl/tcc_back.sv -----
// Byte sequencer: expands queued command records into output words.
module tcc_back import tcc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  cmd_rec_t          q_rec,
    output logic              q_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,
    output logic              m_tuser,
    output logic              m_tlast
);

    cmd_rec_t          cur_reg, cur_next;
    logic              busy_reg, busy_next;
    logic [2:0]        idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_kind_reg, out_kind_next;
    logic              out_last_reg, out_last_next;

    cmd_rec_t          src;
    logic [2:0]        idx;
    logic              advance;
    logic              have_item;
    logic [BYTE_W-1:0] gen_byte;
    logic              gen_kind;
    logic              gen_last;

    assign src       = busy_reg ? cur_reg : q_rec;
    assign idx       = busy_reg ? idx_reg : 3'd0;
    assign advance   = !out_valid_reg || m_tready;
    assign have_item = busy_reg || q_valid;

    always_comb begin
        gen_byte = '0;
        gen_kind = KIND_CONTROL;
        gen_last = 1'b0;
        case (src.kind)
            CMD_TR: begin
                gen_byte = (idx == 3'd0) ? src.num_b : src.num_a;
                gen_last = (idx == 3'd1);
            end
            CMD_RV: begin
                case (idx)
                    3'd0:    gen_byte = RV_STOP_BYTE;
                    3'd2:    gen_byte = RV_REVERSE_BYTE;
                    3'd4:    gen_byte = RV_RESUME_BYTE;
                    default: gen_byte = src.num_a;
                endcase
                gen_last = (idx == 3'd5);
            end
            CMD_SW: begin
                case (idx)
                    3'd0:    gen_byte = src.num_b;
                    3'd1:    gen_byte = src.num_a;
                    default: gen_byte = SW_SOLENOID_OFF;
                endcase
                gen_last = (idx == 3'd2);
            end
            CMD_QUIT: begin
                gen_kind = KIND_QUIT;
                gen_last = 1'b1;
            end
            default: begin
                gen_last = 1'b1;
            end
        endcase
    end

    always_comb begin
        cur_next       = cur_reg;
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_kind_next  = out_kind_reg;
        out_last_next  = out_last_reg;
        q_pop          = 1'b0;
        if (advance) begin
            out_valid_next = have_item;
            if (have_item) begin
                out_byte_next = gen_byte;
                out_kind_next = gen_kind;
                out_last_next = gen_last;
                if (!busy_reg) begin
                    q_pop = 1'b1;
                    if (!gen_last) begin
                        cur_next  = q_rec;
                        busy_next = 1'b1;
                        idx_next  = 3'd1;
                    end
                end else if (gen_last) begin
                    busy_next = 1'b0;
                end else begin
                    idx_next = idx_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg      <= cur_next;
        out_byte_reg <= out_byte_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    a_busy_multi_item: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> ((cur_reg.kind == CMD_TR) || (cur_reg.kind == CMD_RV)
                      || (cur_reg.kind == CMD_SW)))
        else $error("sequencer busy on single-word command");

    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> ((idx_reg >= 3'd1) && (idx_reg <= 3'd5)))
        else $error("sequence index out of range");

    a_quit_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_kind_reg) |-> (out_last_reg && (out_byte_reg == '0)))
        else $error("quit word not a lone zero word");

    a_no_pop_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !q_pop)
        else $error("queue popped during a sequence");

endmodule

// ----- rtl/text_command_to_control_bytes_top.sv -----
// Top level of the text command to control byte converter.
//
//  channel   dir  handshake            payload
//  s_        in   s_tvalid/s_tready    s_tdata[7:0] = char_in
//  m_        out  m_tvalid/m_tready    m_tdata[7:0] = out_byte, m_tuser = item_kind,
//                                      m_tlast = last_of_run
//  cfg_      in   cfg_wr_en            cfg_addr 0 straight_code, 1 curved_code
//
// One character per cycle while s_tready is high. A line's record is queued at its end;
// its words, up to six, then leave one per cycle while m_tready is high.
// s_tready drops only while the record queue (FIFO_DEPTH lines) is full.
// Output stalls back up into the queue; the parser keeps running until it fills.
// Synchronous active-low reset clears line state, queue and output valid, and presets the codes.
module text_command_to_control_bytes_top import tcc_pkg::*; #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [CHAR_W-1:0] s_tdata,     // [7:0] char_in
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,     // [7:0] out_byte
    output logic              m_tuser,     // [0] item_kind
    output logic              m_tlast,
    input  logic              cfg_wr_en,
    input  logic              cfg_addr,
    input  logic [BYTE_W-1:0] cfg_wdata
);

    logic [BYTE_W-1:0] straight_code_reg;
    logic [BYTE_W-1:0] curved_code_reg;

    logic     q_full;
    logic     q_push;
    logic     q_pop;
    logic     q_valid;
    cmd_rec_t push_rec;
    cmd_rec_t head_rec;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            straight_code_reg <= 8'd33;
            curved_code_reg   <= 8'd34;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_STRAIGHT_CODE: straight_code_reg <= cfg_wdata;
                CFG_CURVED_CODE:   curved_code_reg   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    tcc_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .char_valid    (s_tvalid),
        .char_ready    (s_tready),
        .char_in       (s_tdata),
        .straight_code (straight_code_reg),
        .curved_code   (curved_code_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_rec         (push_rec)
    );

    tcc_cmd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_rec  (push_rec),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head_rec  (head_rec)
    );

    tcc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_rec    (head_rec),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
